@@ rtl/htca_pkg.sv @@
package htca_pkg;

  // Default depth of the averaging history
  localparam int HISTORY_DEPTH_DEFAULT = 3;

  // Field widths
  localparam int ByteW    = 8;
  localparam int CodeW    = 20;
  localparam int HumW     = 17;
  localparam int TempW    = 15;
  localparam int InDataW  = 40;
  localparam int OutDataW = 32;

  // Conversion constants: humidity in milli-percent, temperature in centi-degrees
  localparam logic [HumW-1:0]  HumScale   = 17'd100000;
  localparam logic [TempW-1:0] TempScale  = 15'd20000;
  localparam logic [TempW-1:0] TempOffset = 15'd5000;

  // Limits of the converted values
  localparam logic [HumW-1:0]         HumMax  = 17'd99999;
  localparam logic signed [TempW-1:0] TempMin = -15'sd5000;
  localparam logic signed [TempW-1:0] TempMax = 15'sd14999;

  typedef logic [HumW-1:0]         hum_t;
  typedef logic signed [TempW-1:0] temp_t;

  // Five measurement bytes, byte 1 in the lowest bits
  typedef struct packed {
    logic [ByteW-1:0] b5;
    logic [ByteW-1:0] b4;
    logic [ByteW-1:0] b3;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b1;
  } meas_t;

endpackage

@@ rtl/humidity_temperature_convert_average_top.sv @@
// Channel  Direction  Width  Contents (lowest bit first)
// s_*      in         40     meas_byte1, meas_byte2, meas_byte3, meas_byte4, meas_byte5
// m_*      out        32     temperature_avg_centi (15, signed), humidity_avg_milli (17)
//
// Three register stages: conversion, history update, averaging. One measurement
// enters per cycle unless a stalled output has filled the stages; its result is
// registered by each. The history stage updates the running sums once per measurement.
// rst (synchronous) empties the pipeline and clears the primed flag, so the next
// measurement refills the whole history. A stalled output holds each full stage;
// empty stages still take new transfers.
module humidity_temperature_convert_average_top #(
  parameter int HISTORY_DEPTH = htca_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // meas_byte1 [7:0], meas_byte2 [15:8], meas_byte3 [23:16],
  // meas_byte4 [31:24], meas_byte5 [39:32]
  input  logic [htca_pkg::InDataW-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // temperature_avg_centi [14:0], humidity_avg_milli [31:15]
  output logic [htca_pkg::OutDataW-1:0]  m_tdata
);

  // Sum widths grow with the depth of the history
  localparam int DepthBits = $clog2(HISTORY_DEPTH);
  localparam int HumSumW   = htca_pkg::HumW + DepthBits;
  localparam int TempSumW  = htca_pkg::TempW + DepthBits;

  // Division by the depth: multiply by a rounded-up reciprocal and shift.
  // Exact for every sum that fits its width.
  localparam int HumShift   = HumSumW + DepthBits;
  localparam int TempShift  = TempSumW + DepthBits;
  localparam int HumRecipW  = HumSumW + 2;
  localparam int TempRecipW = TempSumW + 2;
  localparam logic [63:0] HumRecip =
    ((64'd1 << HumShift) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [63:0] TempRecip =
    ((64'd1 << TempShift) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam int HumProdW  = HumSumW + HumRecipW;
  localparam int TempProdW = TempSumW + TempRecipW;

  localparam int HumConvW  = htca_pkg::CodeW + htca_pkg::HumW;
  localparam int TempConvW = htca_pkg::CodeW + htca_pkg::TempW;

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves when the one after it is empty or moving
  // ---------------------------------------------------------------------------
  logic conv_valid;
  logic hist_valid;
  logic ready_conv;
  logic ready_hist;
  logic ready_out;

  assign ready_out  = !m_tvalid || m_tready;
  assign ready_hist = !hist_valid || ready_out;
  assign ready_conv = !conv_valid || ready_hist;
  assign s_tready   = ready_conv;

  // ---------------------------------------------------------------------------
  // Stage 1: unpack the raw codes and scale them
  // ---------------------------------------------------------------------------
  htca_pkg::meas_t              meas;
  logic [htca_pkg::CodeW-1:0]   hum_code;
  logic [htca_pkg::CodeW-1:0]   temp_code;
  logic [HumConvW-1:0]          hum_prod;
  logic [TempConvW-1:0]         temp_prod;
  htca_pkg::hum_t               hum_new;
  htca_pkg::temp_t              temp_new;
  htca_pkg::hum_t               hum_conv;
  htca_pkg::temp_t              temp_conv;

  assign meas      = s_tdata;
  assign hum_code  = {meas.b1, meas.b2, meas.b3[7:4]};
  assign temp_code = {meas.b3[3:0], meas.b4, meas.b5};
  assign hum_prod  = HumConvW'(hum_code) * HumConvW'(htca_pkg::HumScale);
  assign temp_prod = TempConvW'(temp_code) * TempConvW'(htca_pkg::TempScale);
  assign hum_new   = hum_prod[htca_pkg::CodeW +: htca_pkg::HumW];
  // The true result always fits 15 signed bits, so the wrap of the subtraction is exact
  assign temp_new  = htca_pkg::temp_t'(temp_prod[htca_pkg::CodeW +: htca_pkg::TempW]
                                       - htca_pkg::TempOffset);

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_valid <= 1'b0;
    end else if (ready_conv) begin
      conv_valid <= s_tvalid;
    end
    if (s_tvalid && ready_conv) begin
      hum_conv  <= hum_new;
      temp_conv <= temp_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: history shift line with running sums
  // ---------------------------------------------------------------------------
  logic                          primed;
  htca_pkg::hum_t                hum_hist  [HISTORY_DEPTH];
  htca_pkg::temp_t               temp_hist [HISTORY_DEPTH];
  logic [HumSumW-1:0]            hum_sum;
  logic signed [TempSumW-1:0]    temp_sum;
  logic [HumSumW-1:0]            hum_sum_next;
  logic signed [TempSumW-1:0]    temp_sum_next;
  logic [HumSumW-1:0]            hum_in_ext;
  logic signed [TempSumW-1:0]    temp_in_ext;
  logic signed [TempSumW-1:0]    temp_old_ext;
  logic                          hist_load;

  assign hist_load    = conv_valid && ready_hist;
  assign hum_in_ext   = HumSumW'(hum_conv);
  assign temp_in_ext  = TempSumW'(temp_conv);
  assign temp_old_ext = TempSumW'(temp_hist[0]);

  // First sample fills every slot: the sum is the sample times the depth.
  // Later samples drop the oldest slot and add the new one.
  always_comb begin
    if (primed) begin
      hum_sum_next  = hum_sum - HumSumW'(hum_hist[0]) + hum_in_ext;
      temp_sum_next = temp_sum - temp_old_ext + temp_in_ext;
    end else begin
      hum_sum_next  = HumSumW'(hum_in_ext * HISTORY_DEPTH);
      temp_sum_next = TempSumW'(temp_in_ext * HISTORY_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= 1'b0;
      primed     <= 1'b0;
    end else begin
      if (ready_hist) begin
        hist_valid <= conv_valid;
      end
      if (hist_load) begin
        primed <= 1'b1;
      end
    end
    if (hist_load) begin
      hum_sum  <= hum_sum_next;
      temp_sum <= temp_sum_next;
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hum_hist[i]  <= primed ? hum_hist[i+1]  : hum_conv;
        temp_hist[i] <= primed ? temp_hist[i+1] : temp_conv;
      end
      hum_hist[HISTORY_DEPTH-1]  <= hum_conv;
      temp_hist[HISTORY_DEPTH-1] <= temp_conv;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide the sums by the depth, truncating toward zero
  // ---------------------------------------------------------------------------
  logic                          temp_neg;
  logic [TempSumW-1:0]           temp_mag;
  logic [TempProdW-1:0]          temp_qprod;
  htca_pkg::temp_t               temp_q;
  logic [HumProdW-1:0]           hum_qprod;
  htca_pkg::hum_t                hum_avg;
  htca_pkg::temp_t               temp_avg;

  // Divide the magnitude so a negative mean rounds toward zero
  assign temp_neg   = temp_sum[TempSumW-1];
  assign temp_mag   = temp_neg ? TempSumW'(-temp_sum) : TempSumW'(temp_sum);
  assign temp_qprod = TempProdW'(temp_mag) * TempProdW'(TempRecip[TempRecipW-1:0]);
  assign temp_q     = htca_pkg::temp_t'(temp_qprod[TempShift +: htca_pkg::TempW]);
  assign hum_qprod  = HumProdW'(hum_sum) * HumProdW'(HumRecip[HumRecipW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready_out) begin
      m_tvalid <= hist_valid;
    end
    if (hist_valid && ready_out) begin
      hum_avg  <= hum_qprod[HumShift +: htca_pkg::HumW];
      temp_avg <= temp_neg ? -temp_q : temp_q;
    end
  end

  assign m_tdata = {hum_avg, temp_avg};

`ifndef SYNTHESIS
  // Nothing can be past the history stage before the first sample has entered it
  a_unprimed_empty: assert property (@(posedge clk) disable iff (rst)
    !primed |-> (!hist_valid && !m_tvalid))
    else $error("history or output stage full before the first sample");

  // The first sample must land in the oldest and newest slots alike
  a_fill_all: assert property (@(posedge clk) disable iff (rst)
    $rose(primed) |-> (hum_hist[0] == hum_hist[HISTORY_DEPTH-1]
                       && temp_hist[0] == temp_hist[HISTORY_DEPTH-1]))
    else $error("first sample did not fill the whole history");

  // A mean of in-range samples stays in range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hum_avg <= htca_pkg::HumMax && temp_avg >= htca_pkg::TempMin
                  && temp_avg <= htca_pkg::TempMax))
    else $error("average out of range");
`endif

endmodule

@@ sim/tb_humidity_temperature_convert_average_top.sv @@
module tb_humidity_temperature_convert_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  import htca_pkg::*;

  localparam int Depth      = HISTORY_DEPTH_DEFAULT;
  localparam int NumRandom  = 1550;
  localparam int CycleLimit = 800_000;
  localparam int HoldAfter  = 500;   // results taken before the long output hold-off
  localparam int HoldCycles = 400;
  localparam int DrainWait  = 12;    // pipeline is three stages deep

  // Output word: temperature in the low 15 bits, humidity above it
  typedef struct packed {
    hum_t  hum;
    temp_t temp;
  } avg_t;

  // Tracks both histories and holds the averages still owed by the block
  class mean_tracker;
    temp_t temp_hist[Depth];
    hum_t  hum_hist[Depth];
    bit    primed;
    avg_t  avg_due[$];
    int    checked;
    int    mismatches;
    int    neg_means;

    function new();
      foreach (temp_hist[i]) begin
        temp_hist[i] = '0;
        hum_hist[i]  = '0;
      end
      primed     = 1'b0;
      checked    = 0;
      mismatches = 0;
      neg_means  = 0;
    endfunction

    // Convert one measurement, update the histories and queue the mean
    function void take_meas(meas_t m);
      logic [CodeW-1:0] hraw;
      logic [CodeW-1:0] traw;
      longint unsigned  hprod;
      longint unsigned  tprod;
      hum_t             h;
      temp_t            t;
      int               tsum;
      int               hsum;
      avg_t             a;
      hraw  = {m.b1, m.b2, m.b3[7:4]};
      traw  = {m.b3[3:0], m.b4, m.b5};
      hprod = 64'(hraw) * 64'd100000;
      tprod = 64'(traw) * 64'd20000;
      h     = hum_t'(hprod >> 20);
      t     = temp_t'(int'(tprod >> 20) - 5000);
      if (!primed) begin
        // first sample after reset loads every slot
        foreach (temp_hist[i]) begin
          temp_hist[i] = t;
          hum_hist[i]  = h;
        end
        primed = 1'b1;
      end else begin
        for (int i = 0; i + 1 < Depth; i++) begin
          temp_hist[i] = temp_hist[i+1];
          hum_hist[i]  = hum_hist[i+1];
        end
        temp_hist[Depth-1] = t;
        hum_hist[Depth-1]  = h;
      end
      tsum = 0;
      hsum = 0;
      foreach (temp_hist[i]) begin
        tsum += int'(temp_hist[i]);
        hsum += int'(hum_hist[i]);
      end
      // integer division truncates toward zero, as the block must
      a.temp = temp_t'(tsum / Depth);
      a.hum  = hum_t'(hsum / Depth);
      if (tsum / Depth < 0) neg_means++;
      avg_due.push_back(a);
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("tb: mismatch at %0t on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Compare one output transfer with the oldest owed average
    function void check_avg(avg_t got);
      avg_t want;
      if (avg_due.size() == 0) begin
        flag("unexpected result (temperature)", 0, int'(got.temp));
        return;
      end
      want = avg_due.pop_front();
      checked++;
      if (got.temp !== want.temp) flag("temperature_avg_centi", int'(want.temp), int'(got.temp));
      if (got.hum !== want.hum) flag("humidity_avg_milli", int'(want.hum), int'(got.hum));
    endfunction
  endclass

  logic  clk;
  logic  rst      = 1'b1;
  logic  s_tvalid = 1'b0;
  logic  s_tready;
  meas_t s_tdata  = '0;
  logic  m_tvalid;
  logic  m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  mean_tracker tracker;
  bit          steady_send = 1'b0;
  int          sent        = 0;
  int          in_stalls   = 0;

  humidity_temperature_convert_average_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic meas_t from_codes(logic [CodeW-1:0] hraw, logic [CodeW-1:0] traw);
    meas_t m;
    m.b1 = hraw[19:12];
    m.b2 = hraw[11:4];
    m.b3 = {hraw[3:0], traw[19:16]};
    m.b4 = traw[15:8];
    m.b5 = traw[7:0];
    return m;
  endfunction

  function automatic logic [CodeW-1:0] edge_code();
    case ($urandom_range(2))
      0:       return '0;
      1:       return '1;
      default: return CodeW'($urandom);
    endcase
  endfunction

  // Offer one measurement and hold it until the block takes the transfer
  task automatic send_meas(meas_t m);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= m;
    @(posedge clk);
    while (!s_tready) begin
      in_stalls++;
      @(posedge clk);
    end
    tracker.take_meas(m);
    sent++;
  endtask

  // Output side: check each transfer, then choose ready for the next cycle
  initial begin : drain
    int stall_left;
    int hold_left;
    bit hold_done;
    bit rdy;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_avg(avg_t'(m_tdata));
      if (!hold_done && tracker.checked >= HoldAfter) begin
        // long hold-off: let the pipeline fill and push back on the input
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ((tracker.checked / 150) % 3 == 1) begin
        rdy = 1'b1;
      end else if ($urandom_range(3) == 0) begin
        stall_left = pick_gap();
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    meas_t m;
    int    r;
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first sample fills the history: minimum of both codes
    send_meas(from_codes('0, '0));
    send_meas(from_codes('1, '1));
    send_meas(from_codes('1, '0));
    send_meas(from_codes('0, '1));
    // nibble split of the shared byte
    send_meas(meas_t'(40'h00_00_F0_00_00));
    send_meas(meas_t'(40'h00_00_0F_00_00));
    send_meas(meas_t'(40'h55_55_55_55_55));
    send_meas(meas_t'(40'hAA_AA_AA_AA_AA));
    send_meas(from_codes(20'h80000, 20'h80000));
    // negative mean with a remainder: truncate toward zero
    send_meas(from_codes('0, '0));
    send_meas(from_codes('0, '0));
    send_meas(from_codes('0, 20'd53));
    // mean just below zero truncates to zero
    send_meas(from_codes(20'h12345, 20'd262092));
    send_meas(from_codes(20'h12345, 20'd262092));
    send_meas(from_codes(20'h12345, 20'd262144));
    send_meas(from_codes(20'h00001, 20'd262092));
    send_meas(from_codes('1, 20'd262091));
    send_meas(from_codes(20'hFFFFE, 20'h7FFFF));

    for (int i = 0; i < NumRandom; i++) begin
      steady_send = ((i / 120) % 4 == 0);
      r = $urandom_range(99);
      if (r < 60) begin
        m.b1 = 8'($urandom);
        m.b2 = 8'($urandom);
        m.b3 = 8'($urandom);
        m.b4 = 8'($urandom);
        m.b5 = 8'($urandom);
      end else if (r < 80) begin
        // cold readings: temperatures mostly below zero degrees
        m = from_codes(CodeW'($urandom), CodeW'($urandom_range(270000)));
      end else if (r < 90) begin
        // hover around zero degrees
        m = from_codes(CodeW'($urandom), CodeW'($urandom_range(262300, 262000)));
      end else begin
        m = from_codes(edge_code(), edge_code());
      end
      send_meas(m);
    end
    s_tvalid <= 1'b0;
    steady_send = 1'b0;

    while (tracker.avg_due.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("tb: %0d measurements sent, %0d averages checked, %0d of them negative",
             sent, tracker.checked, tracker.neg_means);
    $display("tb: input held back for %0d cycles, %0d mismatches", in_stalls,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.avg_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
